[hw/rtl/tis_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Trie insert/search unit package
// Sizes of the node pool and of the alphabet, and the layout of one row of
// the node table.
// ----------------------------------------------------------------------------
package tis_pkg;

    localparam int NODE_COUNT    = 256;
    localparam int ALPHABET_SIZE = 26;

    localparam int NODE_W   = $clog2(NODE_COUNT);
    localparam int FREE_W   = $clog2(NODE_COUNT + 1);
    localparam int LETTER_W = 5;
    localparam int LIDX_W   = $clog2(ALPHABET_SIZE);
    localparam int SLOT_W   = NODE_W + 1;
    localparam int ROW_W    = ALPHABET_SIZE * SLOT_W;

    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_SEARCH = 1'b1;

    // One child slot. The word end mark of a node is kept in the slot of its
    // parent that links to it, so the walk learns it from the row it already
    // reads.
    typedef struct packed {
        logic              end_mark;
        logic [NODE_W-1:0] link;
    } t_slot;

    typedef t_slot [ALPHABET_SIZE-1:0] t_row;

endpackage
`default_nettype wire

[hw/rtl/tis_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with a registered read. The read data
// holds while no read is issued.
// ----------------------------------------------------------------------------
module tis_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

[hw/rtl/trie_insert_search_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Trie insert/search unit
// Walks a prefix tree of lower-case keys, one letter per input transaction.
// ----------------------------------------------------------------------------
// The tree lives in a node table with one row per node; a row holds every
// child link of the node together with the word end mark of each child. For
// each letter the row of the current node is read in the cycle the
// transaction is accepted; then ST_LOOK selects the child, allocates a fresh
// node where an insert finds no link and writes the row back. Only the last
// letter of a key gives a result transaction; it may wait in the output
// register while the next key starts, but a further last letter holds until
// it is taken. After reset the table is cleared row by row, all NODE_COUNT
// rows (256), before the first letter is accepted. Once the pool is used up,
// inserts of new paths report status 1.
// ----------------------------------------------------------------------------
module trie_insert_search_unit (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_s_tvalid,
    output logic            o_s_tready,
    input  wire logic [7:0] i_s_tdata,   // [4:0] letter
    input  wire logic [0:0] i_s_tuser,   // [0] action
    input  wire logic       i_s_tlast,   // last letter of the key
    output logic            o_m_tvalid,
    input  wire logic       i_m_tready,
    output logic      [7:0] o_m_tdata    // [0] found, [1] status
);

    import tis_pkg::*;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOK
    } t_state;

    t_state r_state, n_state;

    logic [NODE_W-1:0]   r_clr, n_clr;
    logic [NODE_W-1:0]   r_cur, n_cur;
    logic                r_failed, n_failed;
    logic                r_ovf, n_ovf;
    logic [FREE_W-1:0]   r_free, n_free;
    logic                r_action, n_action;
    logic [LETTER_W-1:0] r_letter, n_letter;
    logic                r_last, n_last;
    logic                r_out_valid, n_out_valid;
    logic                r_found, n_found;
    logic                r_status, n_status;

    t_row              rd_row, wr_row;
    logic              ram_we, ram_re;
    logic [NODE_W-1:0] ram_waddr;

    logic              letter_ok, pool_left, step_ok, out_free;
    logic [LIDX_W-1:0] lidx;
    t_slot             slot;
    logic              w_failed, w_ovf, w_alloc, w_mark, w_found;
    logic [NODE_W-1:0] w_cur;

    tis_ram #(
        .WIDTH (ROW_W),
        .DEPTH (NODE_COUNT)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (wr_row),
        .i_re    (ram_re),
        .i_raddr (r_cur),
        .o_rdata (rd_row)
    );

    assign o_s_tready = (r_state == ST_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {6'd0, r_status, r_found};

    assign ram_re = o_s_tready && i_s_tvalid;

    // Walk step on the row just read.
    always_comb begin
        letter_ok = (r_letter < LETTER_W'(ALPHABET_SIZE));
        lidx      = letter_ok ? r_letter[LIDX_W-1:0] : '0;
        slot      = rd_row[lidx];
        pool_left = (r_free < FREE_W'(NODE_COUNT));
        step_ok   = !r_failed && letter_ok;

        w_failed = r_failed;
        w_ovf    = r_ovf;
        w_cur    = r_cur;
        w_alloc  = 1'b0;
        if (!r_failed) begin
            if (!letter_ok) begin
                w_failed = 1'b1;
            end else if (slot.link != '0) begin
                w_cur = slot.link;
            end else if (r_action == ACT_INSERT) begin
                if (pool_left) begin
                    w_alloc = 1'b1;
                    w_cur   = r_free[NODE_W-1:0];
                end else begin
                    w_ovf    = 1'b1;
                    w_failed = 1'b1;
                end
            end else begin
                w_failed = 1'b1;
            end
        end

        // The child's word end mark sits in this row beside its link.
        w_mark = r_last && !w_failed && (r_action == ACT_INSERT);
        if (w_failed) begin
            w_found = 1'b0;
        end else if (r_action == ACT_INSERT) begin
            w_found = 1'b1;
        end else begin
            w_found = slot.end_mark;
        end

        wr_row = rd_row;
        if (w_alloc) begin
            wr_row[lidx].link = r_free[NODE_W-1:0];
        end
        if (w_mark) begin
            wr_row[lidx].end_mark = 1'b1;
        end
        if (r_state == ST_CLEAR) begin
            wr_row = '0;
        end
    end

    assign out_free = !r_out_valid || i_m_tready;

    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_cur       = r_cur;
        n_failed    = r_failed;
        n_ovf       = r_ovf;
        n_free      = r_free;
        n_action    = r_action;
        n_letter    = r_letter;
        n_last      = r_last;
        n_out_valid = r_out_valid && !i_m_tready;
        n_found     = r_found;
        n_status    = r_status;
        ram_we      = 1'b0;
        ram_waddr   = r_cur;

        unique case (r_state)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
                n_clr     = r_clr + 1'b1;
                if (r_clr == NODE_W'(NODE_COUNT - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    n_action = i_s_tuser[0];
                    n_letter = i_s_tdata[LETTER_W-1:0];
                    n_last   = i_s_tlast;
                    n_state  = ST_LOOK;
                end
            end
            ST_LOOK: begin
                if (!r_last || out_free) begin
                    ram_we   = step_ok && (w_alloc || w_mark);
                    n_state  = ST_IDLE;
                    n_cur    = w_cur;
                    n_failed = w_failed;
                    n_ovf    = w_ovf;
                    if (w_alloc) begin
                        n_free = r_free + 1'b1;
                    end
                    if (r_last) begin
                        n_out_valid = 1'b1;
                        n_found     = w_found;
                        n_status    = w_ovf;
                        n_cur       = '0;
                        n_failed    = 1'b0;
                        n_ovf       = 1'b0;
                    end
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr       <= '0;
            r_cur       <= '0;
            r_failed    <= 1'b0;
            r_ovf       <= 1'b0;
            r_free      <= FREE_W'(1);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_cur       <= n_cur;
            r_failed    <= n_failed;
            r_ovf       <= n_ovf;
            r_free      <= n_free;
            r_out_valid <= n_out_valid;
        end
        r_action <= n_action;
        r_letter <= n_letter;
        r_last   <= n_last;
        r_found  <= n_found;
        r_status <= n_status;
    end

endmodule
`default_nettype wire

[sim/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trie insert/search unit testbench
// Streams keys letter by letter into the unit and checks every result
// transaction against a prediction of the prefix tree kept alongside. A
// short directed part is followed by random keys that share prefixes, a
// phase that uses up the node pool, random keys against the full pool, and a
// final stretch without idling.
// ----------------------------------------------------------------------------
module tb_top;
    import tis_pkg::*;

    typedef struct packed {
        logic found;
        logic status;
    } trie_result_t;

    // A key of up to eight letters; letters past len are unused.
    typedef struct packed {
        logic [7:0][4:0] ltr;
        logic [3:0]      len;
    } key_t;

    logic       i_clk    = 1'b0;
    logic       i_rst_n  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic [7:0] s_tdata  = '0;    // [4:0] letter
    logic [0:0] s_tuser  = '0;    // [0] action
    logic       s_tlast  = 1'b0;
    logic       m_tready = 1'b0;
    logic       o_s_tready;
    logic       o_m_tvalid;
    logic [7:0] o_m_tdata;        // [0] found, [1] status

    // Prediction of the tree.
    int child_link [NODE_COUNT*ALPHABET_SIZE];
    bit word_end [NODE_COUNT];
    int free_node;
    int walk_node;
    bit walk_failed;
    bit walk_overflow;
    trie_result_t expected_results [$];

    key_t dict [$];
    bit   src_idle_en = 1'b0;
    bit   snk_idle_en = 1'b0;
    int   stall_left  = 0;
    int   n_errors    = 0;
    int   n_letters   = 0;
    int   n_keys      = 0;
    int   n_results   = 0;
    int   n_found     = 0;
    int   n_full      = 0;

    trie_insert_search_unit u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .i_s_tlast  (s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always #5 i_clk = ~i_clk;

    task automatic report_mismatch(input string msg);
        if (n_errors < 20) begin
            $display("ERROR at %0t: %s", $time, msg);
        end
        n_errors++;
    endtask

    function automatic void clear_tree();
        foreach (child_link[i]) child_link[i] = 0;
        foreach (word_end[i]) word_end[i] = 1'b0;
        free_node     = 1;
        walk_node     = 0;
        walk_failed   = 1'b0;
        walk_overflow = 1'b0;
    endfunction

    // Advances the walk by one accepted letter and queues a result on the last one.
    function automatic void walk_letter(input logic act, input logic [4:0] ltr,
                                        input logic lst);
        int slot;
        int child;
        trie_result_t res;
        if (!walk_failed) begin
            if (ltr >= ALPHABET_SIZE) begin
                walk_failed = 1'b1;
            end else begin
                slot  = walk_node * ALPHABET_SIZE + int'(ltr);
                child = child_link[slot];
                if (child != 0) begin
                    walk_node = child;
                end else if (act == ACT_SEARCH) begin
                    walk_failed = 1'b1;
                end else if (free_node < NODE_COUNT) begin
                    child_link[slot]    = free_node;
                    word_end[free_node] = 1'b0;
                    walk_node           = free_node;
                    free_node++;
                end else begin
                    walk_overflow = 1'b1;
                    walk_failed   = 1'b1;
                end
            end
        end
        if (lst) begin
            if (walk_failed) begin
                res.found = 1'b0;
            end else if (act == ACT_INSERT) begin
                word_end[walk_node] = 1'b1;
                res.found           = 1'b1;
            end else begin
                res.found = word_end[walk_node];
            end
            res.status = walk_overflow;
            expected_results.push_back(res);
            walk_node     = 0;
            walk_failed   = 1'b0;
            walk_overflow = 1'b0;
        end
    endfunction

    // Valid is only lowered when a gap follows, so back-to-back letters never
    // see it dropped and raised in the same step.
    task automatic send_letter(input logic act, input logic [4:0] ltr, input logic lst);
        int gap;
        gap = 0;
        if (src_idle_en && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 12);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, ltr};
        s_tuser  <= act;
        s_tlast  <= lst;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        walk_letter(act, ltr, lst);
        n_letters++;
        if (lst) n_keys++;
    endtask

    task automatic send_key(input key_t k, input logic act, input bit mixed);
        for (int i = 0; i < int'(k.len); i++) begin
            if (mixed) act = logic'($urandom_range(0, 1));
            send_letter(act, k.ltr[i], i == int'(k.len) - 1);
        end
    endtask

    function automatic key_t make_key(input int min_len, input int max_len,
                                      input bit allow_bad);
        key_t k;
        k     = '0;
        k.len = 4'($urandom_range(min_len, max_len));
        for (int i = 0; i < int'(k.len); i++) begin
            if (allow_bad && $urandom_range(0, 39) == 0) k.ltr[i] = 5'($urandom_range(26, 31));
            else k.ltr[i] = 5'($urandom_range(0, ALPHABET_SIZE - 1));
        end
        return k;
    endfunction

    // Result checking and receiver stalls.
    always @(posedge i_clk) begin
        trie_result_t want;
        if (i_rst_n && o_m_tvalid && m_tready) begin
            n_results++;
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result, tdata %02h", o_m_tdata));
            end else begin
                want = expected_results.pop_front();
                if (o_m_tdata[0] !== want.found) begin
                    report_mismatch($sformatf("found %b, expected %b", o_m_tdata[0], want.found));
                end
                if (o_m_tdata[1] !== want.status) begin
                    report_mismatch($sformatf("status %b, expected %b",
                                              o_m_tdata[1], want.status));
                end
                if (o_m_tdata[7:2] !== 6'b0) begin
                    report_mismatch($sformatf("padding bits %b not zero", o_m_tdata[7:2]));
                end
                if (want.found) n_found++;
                if (want.status) n_full++;
            end
        end
        if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if (snk_idle_en && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 11);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic test_directed_paths();
        src_idle_en = 1'b1;
        snk_idle_en = 1'b1;
        send_letter(ACT_INSERT, 5'd0, 1'b1);     // "a" stored
        send_letter(ACT_SEARCH, 5'd0, 1'b1);     // "a" found
        send_letter(ACT_SEARCH, 5'd25, 1'b1);    // "z" absent
        send_letter(ACT_INSERT, 5'd25, 1'b0);    // "za" stored
        send_letter(ACT_INSERT, 5'd0, 1'b1);
        send_letter(ACT_SEARCH, 5'd25, 1'b1);    // "z" is a path but not a word
        send_letter(ACT_SEARCH, 5'd25, 1'b0);    // "za" found
        send_letter(ACT_SEARCH, 5'd0, 1'b1);
        send_letter(ACT_INSERT, 5'd31, 1'b1);    // letters beyond z fail the walk
        send_letter(ACT_SEARCH, 5'd26, 1'b1);
        send_letter(ACT_INSERT, 5'd0, 1'b0);     // a bad letter mid-key allocates nothing
        send_letter(ACT_INSERT, 5'd30, 1'b0);
        send_letter(ACT_INSERT, 5'd1, 1'b1);
        send_letter(ACT_INSERT, 5'd2, 1'b0);     // a search letter ends an insert key
        send_letter(ACT_SEARCH, 5'd3, 1'b1);
        send_letter(ACT_SEARCH, 5'd25, 1'b0);    // an insert letter ends a search key
        send_letter(ACT_INSERT, 5'd1, 1'b1);
        send_letter(ACT_SEARCH, 5'd25, 1'b0);
        send_letter(ACT_SEARCH, 5'd1, 1'b1);
    endtask

    // Mostly well-formed keys over a growing dictionary, so that searches hit,
    // miss on prefixes and extensions, and inserts share existing paths.
    task automatic test_random_keys(input int n_items, input bit allow_idle);
        int   start;
        int   sel;
        int   pick;
        key_t k;
        start = n_letters;
        src_idle_en = allow_idle;
        snk_idle_en = allow_idle;
        while (n_letters - start < n_items) begin
            if (allow_idle && $urandom_range(0, 9) == 0) begin
                src_idle_en = $urandom_range(0, 2) != 0;
                snk_idle_en = $urandom_range(0, 2) != 0;
            end
            sel  = $urandom_range(0, 99);
            pick = (dict.size() > 0) ? $urandom_range(0, dict.size() - 1) : 0;
            if (sel < 40 || dict.size() == 0) begin
                k = make_key(1, 6, 1'b1);
                if (dict.size() > 0 && $urandom_range(0, 2) == 0) begin
                    k = dict[pick];
                    while (k.len < 4'd8 && $urandom_range(0, 2) != 0) begin
                        k.ltr[k.len] = 5'($urandom_range(0, ALPHABET_SIZE - 1));
                        k.len++;
                    end
                end
                send_key(k, ACT_INSERT, 1'b0);
                if (dict.size() < 64) dict.push_back(k);
                else dict[pick] = k;
            end else if (sel < 75) begin
                k = dict[pick];
                case ($urandom_range(0, 4))
                    0: k.len = 4'($urandom_range(1, k.len));
                    1: if (k.len < 4'd8) begin
                        k.ltr[k.len] = 5'($urandom_range(0, ALPHABET_SIZE - 1));
                        k.len++;
                    end
                    default: ;
                endcase
                send_key(k, ACT_SEARCH, 1'b0);
            end else if (sel < 88) begin
                send_key(make_key(1, 6, 1'b1), ACT_SEARCH, 1'b0);
            end else begin
                k = (dict.size() > 0 && $urandom_range(0, 1) == 0) ? dict[pick]
                                                                   : make_key(1, 6, 1'b1);
                send_key(k, ACT_INSERT, 1'b1);
            end
        end
    endtask

    // Fills the pool with long keys, then runs keys into the empty pool.
    task automatic test_pool_exhaustion();
        key_t k;
        key_t cut_key;
        src_idle_en = 1'b1;
        snk_idle_en = 1'b1;
        while (free_node < NODE_COUNT - 3) begin
            k = make_key(8, 8, 1'b0);
            send_key(k, ACT_INSERT, 1'b0);
            dict.push_back(k);
        end
        // Allocates the last few nodes and then runs out part-way through.
        cut_key = make_key(8, 8, 1'b0);
        send_key(cut_key, ACT_INSERT, 1'b0);
        send_key(cut_key, ACT_SEARCH, 1'b0);
        for (int i = 0; i < 4; i++) begin
            send_key(make_key(1, 5, 1'b0), ACT_INSERT, 1'b0);
        end
        send_key(dict[0], ACT_INSERT, 1'b0);
        send_key(dict[dict.size() - 1], ACT_SEARCH, 1'b0);
    endtask

    initial begin
        clear_tree();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_paths();
        test_random_keys(380, 1'b1);
        test_pool_exhaustion();
        test_random_keys(340, 1'b1);
        test_random_keys(100, 1'b0);
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        $display("Sent %0d letters in %0d keys; %0d nodes of %0d allocated.",
                 n_letters, n_keys, free_node - 1, NODE_COUNT - 1);
        $display("Checked %0d results: %0d found, %0d with the pool full.",
                 n_results, n_found, n_full);
        if (n_errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Timed out waiting for the unit.");
        $display("FAILURE");
        $finish;
    end

endmodule
